// File: sv/tapered_segment_distance_map_assert.svh
// assertion helpers, clocked on clk and disabled in rst
`ifndef TAPERED_SEGMENT_DISTANCE_MAP_ASSERT_SVH
`define TAPERED_SEGMENT_DISTANCE_MAP_ASSERT_SVH

// same-cycle implication
`define TSDM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tsdm_pkg.sv
`default_nettype none

package tsdm_pkg;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  localparam logic signed [23:0] D_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] D_MIN = -24'sh800000;

  // shared iterative units
  localparam int DIV_W     = 53;
  localparam int DEN_W     = 26;
  localparam int SQ_IN_W   = 54;
  localparam int SQ_ROOT_W = 27;
  localparam int SQ_REM_W  = 29;
  localparam int SAT_W     = 55;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [23:0] prox_x;
    logic signed [23:0] prox_y;
    logic signed [23:0] dist_x;
    logic signed [23:0] dist_y;
    logic [19:0]        prox_radius;
    logic [19:0]        dist_radius;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [23:0] distance;
    logic               inside_res;
  } result_t;

  typedef struct packed {
    logic signed [23:0] prox_x;
    logic signed [23:0] prox_y;
    logic signed [23:0] dist_x;
    logic signed [23:0] dist_y;
    logic [19:0]        prox_rad;
    logic [19:0]        dist_rad;
  } seg_t;

  function automatic logic signed [23:0] sat24(input logic signed [SAT_W-1:0] v);
    logic signed [23:0] r;
    if (v > SAT_W'(D_MAX)) begin
      r = D_MAX;
    end else if (v < SAT_W'(D_MIN)) begin
      r = D_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/tapered_segment_distance_map.sv
// clear and load: the request goes to the finish state, which loads the result register; table write at acceptance
// query: walks the stored segments in turn, each by projection on the segment
//   or by the endpoint case; one bit per cycle square root and divider
// one request in flight; a finished result waits in the output register
// reset clears the segment count and the control state; the table is not cleared
`default_nettype none

module tapered_segment_distance_map #(
  parameter int MAX_SEGMENTS = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire tsdm_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output tsdm_pkg::result_t     result
);

`include "tapered_segment_distance_map_assert.svh"

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_DIFF = 5'd2;
  localparam logic [4:0] S_MUL1 = 5'd3;
  localparam logic [4:0] S_SUM1 = 5'd4;
  localparam logic [4:0] S_MUL2 = 5'd5;
  localparam logic [4:0] S_SUM2 = 5'd6;
  localparam logic [4:0] S_SQS  = 5'd7;
  localparam logic [4:0] S_DIVP = 5'd8;
  localparam logic [4:0] S_DIVQ = 5'd9;
  localparam logic [4:0] S_MULR = 5'd10;
  localparam logic [4:0] S_RABS = 5'd11;
  localparam logic [4:0] S_DIVR = 5'd12;
  localparam logic [4:0] S_MUL3 = 5'd13;
  localparam logic [4:0] S_SUM3 = 5'd14;
  localparam logic [4:0] S_SQB  = 5'd15;
  localparam logic [4:0] S_SQA  = 5'd16;
  localparam logic [4:0] S_UPD  = 5'd17;
  localparam logic [4:0] S_FIN  = 5'd18;

  localparam logic [5:0] SQ_LAST  = 6'(tsdm_pkg::SQ_ROOT_W - 1);
  localparam logic [5:0] DIV_LAST = 6'(tsdm_pkg::DIV_W - 1);

  logic [4:0]  state;
  logic [5:0]  cnt;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_inc;

  tsdm_pkg::seg_t mem [MAX_SEGMENTS];
  tsdm_pkg::seg_t rdata;
  tsdm_pkg::seg_t wdata;
  logic           mem_we;
  logic           accept;
  logic           endp_eq;

  tsdm_pkg::result_t res;
  logic signed [23:0] best;
  logic               inside_any;
  logic [11:0]        pix_x;
  logic [11:0]        pix_y;

  logic signed [25:0] abx, aby, acx, acy, bcx, bcy;
  logic [19:0]        rp, rd;
  logic signed [20:0] rdiff;
  logic signed [51:0] m0, m1, m2, m3;
  logic signed [52:0] l2, d, nb, na;
  logic signed [52:0] cr_diff;
  logic [52:0]        cr;
  logic               on_seg;
  logic [25:0]        s;
  logic [25:0]        s_new;
  logic [52:0]        perp;
  logic [25:0]        q;
  logic signed [47:0] prod;
  logic               pneg;
  logic signed [21:0] rad;
  logic signed [27:0] ep, ed;

  // square root unit
  logic [tsdm_pkg::SQ_IN_W-1:0]   sq_in;
  logic [tsdm_pkg::SQ_REM_W-1:0]  sq_rem;
  logic [tsdm_pkg::SQ_ROOT_W-1:0] sq_root;
  logic [30:0]                    sq_sh, sq_trial, sq_sub;
  logic                           sq_ge;
  logic [tsdm_pkg::SQ_REM_W-1:0]  sq_rem_next;
  logic [tsdm_pkg::SQ_ROOT_W-1:0] sq_root_next;

  // restoring divider
  logic [tsdm_pkg::DIV_W-1:0] dv_num;
  logic [tsdm_pkg::DEN_W-1:0] dv_den;
  logic [tsdm_pkg::DEN_W-1:0] dv_rem;
  logic [tsdm_pkg::DIV_W-1:0] dv_quo;
  logic [tsdm_pkg::DEN_W:0]   dv_sh, dv_sub;
  logic                       dv_ge;
  logic [tsdm_pkg::DEN_W-1:0] dv_rem_next;
  logic [tsdm_pkg::DIV_W-1:0] dv_quo_next;
  logic                       dv_run;

  // segment update
  logic signed [tsdm_pkg::SAT_W-1:0] upd_diff;
  logic signed [27:0]                upd_e;
  logic signed [23:0]                cand;
  logic signed [23:0]                best_next;
  logic                              inside_next;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign endp_eq    = (item.prox_x == item.dist_x) && (item.prox_y == item.dist_y);
  assign mem_we     = accept && (item.action == tsdm_pkg::ACT_LOAD) &&
                      (count != CW'(MAX_SEGMENTS)) && !endp_eq;
  assign idx_inc    = idx + CW'(1);
  assign dv_run     = (state == S_DIVP) || (state == S_DIVQ) || (state == S_DIVR);

  always_comb begin
    wdata.prox_x   = item.prox_x;
    wdata.prox_y   = item.prox_y;
    wdata.dist_x   = item.dist_x;
    wdata.dist_y   = item.dist_y;
    wdata.prox_rad = item.prox_radius;
    wdata.dist_rad = item.dist_radius;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IW-1:0]] <= wdata;
    end
    rdata <= mem[idx[IW-1:0]];
  end

  always_comb begin
    sq_sh        = {sq_rem, sq_in[tsdm_pkg::SQ_IN_W-1 -: 2]};
    sq_trial     = {2'b00, sq_root, 2'b01};
    sq_ge        = (sq_sh >= sq_trial);
    sq_sub       = sq_sh - sq_trial;
    sq_rem_next  = sq_ge ? sq_sub[tsdm_pkg::SQ_REM_W-1:0] : sq_sh[tsdm_pkg::SQ_REM_W-1:0];
    sq_root_next = {sq_root[tsdm_pkg::SQ_ROOT_W-2:0], sq_ge};
    s_new        = (sq_root_next == '0) ? 26'd1 : sq_root_next[25:0];
  end

  always_comb begin
    dv_sh       = {dv_rem, dv_num[tsdm_pkg::DIV_W-1]};
    dv_ge       = (dv_sh >= {1'b0, dv_den});
    dv_sub      = dv_sh - {1'b0, dv_den};
    dv_rem_next = dv_ge ? dv_sub[tsdm_pkg::DEN_W-1:0] : dv_sh[tsdm_pkg::DEN_W-1:0];
    dv_quo_next = {dv_quo[tsdm_pkg::DIV_W-2:0], dv_ge};
  end

  assign cr_diff = 53'(m0) - 53'(m1);

  always_comb begin
    upd_diff    = $signed({2'b00, perp}) - tsdm_pkg::SAT_W'(rad);
    upd_e       = (ep < ed) ? ep : ed;
    best_next   = best;
    inside_next = inside_any;
    if (on_seg) begin
      cand = tsdm_pkg::sat24(upd_diff);
      if (cand < best) begin
        best_next = cand[23] ? 24'sd0 : cand;
      end
      if (upd_diff[tsdm_pkg::SAT_W-1]) begin
        inside_next = 1'b1;
      end
    end else begin
      cand = tsdm_pkg::sat24(tsdm_pkg::SAT_W'(upd_e));
      if (cand < best) begin
        best_next = cand;
      end
      if (upd_e[27]) begin
        inside_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      idx          <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res.inside_res <= 1'b0;
            unique case (item.action)
              tsdm_pkg::ACT_CLEAR: begin
                count        <= '0;
                res.status   <= tsdm_pkg::ST_OK;
                res.distance <= '0;
                state        <= S_FIN;
              end
              tsdm_pkg::ACT_LOAD: begin
                res.distance <= '0;
                state        <= S_FIN;
                if (count == CW'(MAX_SEGMENTS)) begin
                  res.status <= tsdm_pkg::ST_FULL;
                end else if (endp_eq) begin
                  res.status <= tsdm_pkg::ST_DEGEN;
                end else begin
                  res.status <= tsdm_pkg::ST_OK;
                  count      <= count + CW'(1);
                end
              end
              tsdm_pkg::ACT_QUERY: begin
                res.status <= tsdm_pkg::ST_OK;
                pix_x      <= item.pixel_x;
                pix_y      <= item.pixel_y;
                best       <= tsdm_pkg::D_MAX;
                inside_any <= 1'b0;
                idx        <= '0;
                if (count == '0) begin
                  res.distance <= tsdm_pkg::D_MAX;
                  state        <= S_FIN;
                end else begin
                  state <= S_RD;
                end
              end
              default: begin
                res.status   <= tsdm_pkg::ST_OK;
                res.distance <= '0;
                state        <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          abx   <= 26'(rdata.prox_x) - 26'(rdata.dist_x);
          aby   <= 26'(rdata.prox_y) - 26'(rdata.dist_y);
          acx   <= $signed({6'd0, pix_x, 8'd0}) - 26'(rdata.dist_x);
          acy   <= $signed({6'd0, pix_y, 8'd0}) - 26'(rdata.dist_y);
          bcx   <= $signed({6'd0, pix_x, 8'd0}) - 26'(rdata.prox_x);
          bcy   <= $signed({6'd0, pix_y, 8'd0}) - 26'(rdata.prox_y);
          rp    <= rdata.prox_rad;
          rd    <= rdata.dist_rad;
          rdiff <= $signed({1'b0, rdata.dist_rad}) - $signed({1'b0, rdata.prox_rad});
          state <= S_MUL1;
        end
        S_MUL1: begin
          m0    <= abx * abx;
          m1    <= aby * aby;
          m2    <= acx * abx;
          m3    <= acy * aby;
          state <= S_SUM1;
        end
        S_SUM1: begin
          l2    <= 53'(m0) + 53'(m1);
          d     <= 53'(m2) + 53'(m3);
          state <= S_MUL2;
        end
        S_MUL2: begin
          m0    <= acx * aby;
          m1    <= acy * abx;
          m2    <= bcx * bcx;
          m3    <= bcy * bcy;
          state <= S_SUM2;
        end
        S_SUM2: begin
          cr     <= cr_diff[52] ? 53'(-cr_diff) : 53'(cr_diff);
          nb     <= 53'(m2) + 53'(m3);
          on_seg <= (d >= 0) && (d <= l2);
          if ((d >= 0) && (d <= l2)) begin
            sq_in   <= {1'b0, l2};
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= '0;
            state   <= S_SQS;
          end else begin
            state <= S_MUL3;
          end
        end
        S_SQS: begin
          if (cnt == SQ_LAST) begin
            s      <= s_new;
            dv_num <= cr;
            dv_den <= s_new;
            dv_rem <= '0;
            dv_quo <= '0;
            cnt    <= '0;
            state  <= S_DIVP;
          end else begin
            sq_in   <= sq_in << 2;
            sq_rem  <= sq_rem_next;
            sq_root <= sq_root_next;
            cnt     <= cnt + 6'd1;
          end
        end
        S_DIVP: begin
          if (cnt == DIV_LAST) begin
            perp   <= dv_quo_next;
            dv_num <= 53'(l2 - d);
            dv_rem <= '0;
            dv_quo <= '0;
            cnt    <= '0;
            state  <= S_DIVQ;
          end else begin
            dv_num <= dv_num << 1;
            dv_rem <= dv_rem_next;
            dv_quo <= dv_quo_next;
            cnt    <= cnt + 6'd1;
          end
        end
        S_DIVQ: begin
          if (cnt == DIV_LAST) begin
            q     <= (dv_quo_next > 53'(s)) ? s : dv_quo_next[25:0];
            state <= S_MULR;
          end else begin
            dv_num <= dv_num << 1;
            dv_rem <= dv_rem_next;
            dv_quo <= dv_quo_next;
            cnt    <= cnt + 6'd1;
          end
        end
        S_MULR: begin
          prod  <= rdiff * $signed({1'b0, q});
          state <= S_RABS;
        end
        S_RABS: begin
          pneg   <= prod[47];
          dv_num <= prod[47] ? 53'(-prod) : 53'(prod);
          dv_rem <= '0;
          dv_quo <= '0;
          cnt    <= '0;
          state  <= S_DIVR;
        end
        S_DIVR: begin
          if (cnt == DIV_LAST) begin
            // truncation toward zero: divide the magnitude, then restore the sign
            rad   <= pneg ? ($signed({2'b00, rp}) - $signed({1'b0, dv_quo_next[20:0]}))
                          : ($signed({2'b00, rp}) + $signed({1'b0, dv_quo_next[20:0]}));
            state <= S_UPD;
          end else begin
            dv_num <= dv_num << 1;
            dv_rem <= dv_rem_next;
            dv_quo <= dv_quo_next;
            cnt    <= cnt + 6'd1;
          end
        end
        S_MUL3: begin
          m2    <= acx * acx;
          m3    <= acy * acy;
          state <= S_SUM3;
        end
        S_SUM3: begin
          na      <= 53'(m2) + 53'(m3);
          sq_in   <= {1'b0, nb};
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= '0;
          state   <= S_SQB;
        end
        S_SQB: begin
          if (cnt == SQ_LAST) begin
            ep      <= $signed({1'b0, sq_root_next}) - $signed({8'd0, rp});
            sq_in   <= {1'b0, na};
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= '0;
            state   <= S_SQA;
          end else begin
            sq_in   <= sq_in << 2;
            sq_rem  <= sq_rem_next;
            sq_root <= sq_root_next;
            cnt     <= cnt + 6'd1;
          end
        end
        S_SQA: begin
          if (cnt == SQ_LAST) begin
            ed    <= $signed({1'b0, sq_root_next}) - $signed({8'd0, rd});
            state <= S_UPD;
          end else begin
            sq_in   <= sq_in << 2;
            sq_rem  <= sq_rem_next;
            sq_root <= sq_root_next;
            cnt     <= cnt + 6'd1;
          end
        end
        S_UPD: begin
          best       <= best_next;
          inside_any <= inside_next;
          if (idx_inc == count) begin
            res.status     <= tsdm_pkg::ST_OK;
            res.distance   <= best_next;
            res.inside_res <= inside_next;
            state          <= S_FIN;
          end else begin
            idx   <= idx_inc;
            state <= S_RD;
          end
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result <= res;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TSDM_ASSERT(a_count_bound, 1'b1, count <= CW'(MAX_SEGMENTS), "segment count beyond table depth")
  `TSDM_ASSERT(a_rd_in_table, state == S_RD, idx < count, "segment read beyond fill count")
  `TSDM_ASSERT(a_den_nonzero, dv_run, dv_den != '0, "divide by zero length")
  `TSDM_ASSERT_NEXT(a_clear_empties, accept && item.action == tsdm_pkg::ACT_CLEAR, count == '0, "clear left segments")

endmodule

`default_nettype wire

// File: tb/tapered_segment_distance_map_tb.sv
module tapered_segment_distance_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam int HOLD_CYCLES = 3000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  tsdm_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  tsdm_pkg::result_t result;

  tapered_segment_distance_map dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // own copy of the segment table
  logic signed [23:0] tbl_prox_x [TABLE_DEPTH];
  logic signed [23:0] tbl_prox_y [TABLE_DEPTH];
  logic signed [23:0] tbl_dist_x [TABLE_DEPTH];
  logic signed [23:0] tbl_dist_y [TABLE_DEPTH];
  logic [19:0]        tbl_prox_rad [TABLE_DEPTH];
  logic [19:0]        tbl_dist_rad [TABLE_DEPTH];
  int                 seg_total = 0;

  tsdm_pkg::result_t pending_results[$];
  int      error_count = 0;
  int      hold_requests = 0;

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // distance map result for one request, updating the table copy
  function automatic tsdm_pkg::result_t segment_distance(tsdm_pkg::item_t it);
    tsdm_pkg::result_t r;
    longint best, cx, cy, ax, ay, bx, by, rp, rd, abx, aby, acx, acy, l2, d;
    longint s, cr, perp, q, rad, cand, ep, ed, e;
    r = '0;
    best = 0;
    case (it.action)
      tsdm_pkg::ACT_CLEAR: seg_total = 0;
      tsdm_pkg::ACT_LOAD: begin
        if (seg_total >= TABLE_DEPTH) begin
          r.status = tsdm_pkg::ST_FULL;
        end else if (it.prox_x == it.dist_x && it.prox_y == it.dist_y) begin
          r.status = tsdm_pkg::ST_DEGEN;
        end else begin
          tbl_prox_x[seg_total] = it.prox_x;
          tbl_prox_y[seg_total] = it.prox_y;
          tbl_dist_x[seg_total] = it.dist_x;
          tbl_dist_y[seg_total] = it.dist_y;
          tbl_prox_rad[seg_total] = it.prox_radius;
          tbl_dist_rad[seg_total] = it.dist_radius;
          seg_total++;
        end
      end
      tsdm_pkg::ACT_QUERY: begin
        cx = longint'(it.pixel_x) * 256;
        cy = longint'(it.pixel_y) * 256;
        best = 64'sd8388607;
        for (int i = 0; i < seg_total; i++) begin
          ax = tbl_dist_x[i];
          ay = tbl_dist_y[i];
          bx = tbl_prox_x[i];
          by = tbl_prox_y[i];
          rp = longint'(tbl_prox_rad[i]);
          rd = longint'(tbl_dist_rad[i]);
          abx = bx - ax;
          aby = by - ay;
          acx = cx - ax;
          acy = cy - ay;
          l2 = abx * abx + aby * aby;
          d = acx * abx + acy * aby;
          if (d >= 0 && d <= l2) begin
            s = root_floor(l2);
            if (s < 1) s = 1;
            cr = acx * aby - acy * abx;
            if (cr < 0) cr = -cr;
            perp = cr / s;
            q = (l2 - d) / s;
            if (q > s) q = s;
            rad = rp + ((rd - rp) * q) / s;
            cand = clamp24(perp - rad);
            if (cand < best) best = (cand < 0) ? 0 : cand;
            if (perp < rad) r.inside_res = 1'b1;
          end else begin
            ep = root_floor((cx - bx) * (cx - bx) + (cy - by) * (cy - by)) - rp;
            ed = root_floor(acx * acx + acy * acy) - rd;
            e = (ep < ed) ? ep : ed;
            cand = clamp24(e);
            if (cand < best) best = cand;
            if (e < 0) r.inside_res = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.distance = best[23:0];
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 0;

  task automatic offer(tsdm_pkg::item_t it, bit has_typed, tsdm_pkg::result_t typed);
    tsdm_pkg::result_t predicted;
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    predicted = segment_distance(it);
    pending_results = {pending_results, (has_typed ? typed : predicted)};
  endtask

  task automatic send(tsdm_pkg::item_t it);
    offer(it, 1'b0, '0);
  endtask

  function automatic logic signed [23:0] coord_near();
    return 24'($signed($urandom_range(0, 1050000)) - 1000);
  endfunction

  function automatic tsdm_pkg::item_t make_load(bit wide);
    tsdm_pkg::item_t it;
    it = '0;
    it.action = tsdm_pkg::ACT_LOAD;
    if (wide) begin
      it.prox_x = 24'($urandom);
      it.prox_y = 24'($urandom);
      it.dist_x = 24'($urandom);
      it.dist_y = 24'($urandom);
      it.prox_radius = 20'($urandom);
      it.dist_radius = 20'($urandom);
    end else begin
      it.prox_x = coord_near();
      it.prox_y = coord_near();
      it.dist_x = coord_near();
      it.dist_y = coord_near();
      it.prox_radius = 20'($urandom_range(0, 40000));
      it.dist_radius = 20'($urandom_range(0, 40000));
    end
    // pixel fields carry noise on loads
    it.pixel_x = 12'($urandom);
    it.pixel_y = 12'($urandom);
    return it;
  endfunction

  function automatic tsdm_pkg::item_t make_query();
    tsdm_pkg::item_t it;
    it = $urandom_range(0, 1) ? make_load(1'b1) : make_load(1'b0);
    it.action = tsdm_pkg::ACT_QUERY;
    it.pixel_x = 12'($urandom);
    it.pixel_y = 12'($urandom);
    return it;
  endfunction

  typedef struct {
    tsdm_pkg::item_t   stim;
    bit                has_typed;
    tsdm_pkg::result_t typed;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic stim_row_t row(tsdm_pkg::item_t it, bit has_typed,
                                    tsdm_pkg::result_t typed);
    stim_row_t s;
    s.stim = it;
    s.has_typed = has_typed;
    s.typed = typed;
    return s;
  endfunction

  function automatic void add_row(tsdm_pkg::item_t it, bit has_typed,
                                  tsdm_pkg::result_t typed);
    directed = {directed, row(it, has_typed, typed)};
  endfunction

  function automatic tsdm_pkg::item_t seg_item(logic signed [23:0] px, logic signed [23:0] py,
                                               logic signed [23:0] qx, logic signed [23:0] qy,
                                               logic [19:0] pr, logic [19:0] dr);
    tsdm_pkg::item_t it;
    it = '0;
    it.action = tsdm_pkg::ACT_LOAD;
    it.prox_x = px;
    it.prox_y = py;
    it.dist_x = qx;
    it.dist_y = qy;
    it.prox_radius = pr;
    it.dist_radius = dr;
    return it;
  endfunction

  function automatic tsdm_pkg::item_t pixel_item(logic [11:0] x, logic [11:0] y);
    tsdm_pkg::item_t it;
    it = '0;
    it.action = tsdm_pkg::ACT_QUERY;
    it.pixel_x = x;
    it.pixel_y = y;
    return it;
  endfunction

  function automatic tsdm_pkg::result_t res(logic [1:0] st, logic signed [23:0] dv);
    tsdm_pkg::result_t r;
    r.status = st;
    r.distance = dv;
    r.inside_res = 1'b0;
    return r;
  endfunction

  initial begin
    tsdm_pkg::item_t it;
    int    sent;

    it = '0;
    it.action = tsdm_pkg::ACT_CLEAR;
    add_row(pixel_item(12'd0, 12'd0), 1'b1, res(tsdm_pkg::ST_OK, tsdm_pkg::D_MAX));
    add_row(it, 1'b1, res(tsdm_pkg::ST_OK, '0));
    add_row(seg_item(24'sd2560, 24'sd2560, 24'sd2560, 24'sd2560, 20'd5, 20'd5),
            1'b1, res(tsdm_pkg::ST_DEGEN, '0));
    add_row(pixel_item(12'd4095, 12'd4095), 1'b1, res(tsdm_pkg::ST_OK, tsdm_pkg::D_MAX));
    // horizontal tapered segment from (10,10) to (40,10)
    add_row(seg_item(24'sd2560, 24'sd2560, 24'sd10240, 24'sd2560, 20'd1280, 20'd256),
            1'b1, res(tsdm_pkg::ST_OK, '0));
    add_row(pixel_item(12'd20, 12'd12), 1'b0, '0);
    add_row(pixel_item(12'd10, 12'd10), 1'b0, '0);
    add_row(pixel_item(12'd40, 12'd30), 1'b0, '0);
    add_row(pixel_item(12'd0, 12'd10), 1'b0, '0);
    add_row(pixel_item(12'd4095, 12'd0), 1'b0, '0);
    // extreme coordinates and radii
    add_row(seg_item(tsdm_pkg::D_MIN, tsdm_pkg::D_MIN, tsdm_pkg::D_MAX, tsdm_pkg::D_MAX,
                     20'hFFFFF, 20'h0), 1'b1, res(tsdm_pkg::ST_OK, '0));
    add_row(seg_item(tsdm_pkg::D_MAX, tsdm_pkg::D_MIN, tsdm_pkg::D_MIN, tsdm_pkg::D_MAX,
                     20'h0, 20'hFFFFF), 1'b1, res(tsdm_pkg::ST_OK, '0));
    add_row(pixel_item(12'd0, 12'd4095), 1'b0, '0);
    add_row(pixel_item(12'd2048, 12'd2048), 1'b0, '0);
    // unused action code does nothing
    it = make_load(1'b1);
    it.action = tsdm_pkg::ACT_NOP;
    add_row(it, 1'b1, res(tsdm_pkg::ST_OK, '0));
    // single point segment degenerate after loads
    add_row(seg_item(tsdm_pkg::D_MIN, tsdm_pkg::D_MAX, tsdm_pkg::D_MIN, tsdm_pkg::D_MAX,
                     20'd1, 20'd1), 1'b1, res(tsdm_pkg::ST_DEGEN, '0));
    add_row(pixel_item(12'd1, 12'd2), 1'b0, '0);
    it = '0;
    it.action = tsdm_pkg::ACT_CLEAR;
    add_row(it, 1'b1, res(tsdm_pkg::ST_OK, '0));
    add_row(pixel_item(12'd100, 12'd100), 1'b1, res(tsdm_pkg::ST_OK, tsdm_pkg::D_MAX));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) offer(directed[i].stim, directed[i].has_typed, directed[i].typed);

    // fill the table, then full-table loads and one full-table query
    it = '0;
    it.action = tsdm_pkg::ACT_CLEAR;
    send(it);
    for (int n = 0; n < TABLE_DEPTH; n++) begin
      if (n == 40) hold_requests = 1;
      if (n == 150) begin
        // sender pause until the block has drained
        item_valid <= 1'b0;
        burst_left = 0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      it = make_load(1'b0);
      if (it.prox_x == it.dist_x && it.prox_y == it.dist_y) it.dist_x = it.dist_x + 24'sd1;
      send(it);
    end
    send(make_load(1'b1));
    it = make_load(1'b0);
    it.dist_x = it.prox_x;
    it.dist_y = it.prox_y;
    send(it);
    send(make_query());
    it = '0;
    it.action = tsdm_pkg::ACT_CLEAR;
    send(it);

    // well-formed sequences: optional clear, a few loads, a few queries, now and then a no-op
    sent = 0;
    while (sent < 14) begin
      if ($urandom_range(0, 2) == 0) begin
        it = make_load(1'b1);
        it.action = tsdm_pkg::ACT_CLEAR;
        send(it);
        sent++;
      end
      repeat ($urandom_range(1, 5)) begin
        it = make_load($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) begin
          it.dist_x = it.prox_x;
          it.dist_y = it.prox_y;
        end
        send(it);
        sent++;
      end
      repeat ($urandom_range(1, 4)) begin
        it = make_query();
        // aim at a stored endpoint now and then
        if (seg_total > 0 && $urandom_range(0, 2) == 0) begin
          int k;
          k = $urandom_range(0, seg_total - 1);
          it.pixel_x = 12'((tbl_prox_x[k] >>> 8) + $signed($urandom_range(0, 6)) - 3);
          it.pixel_y = 12'((tbl_prox_y[k] >>> 8) + $signed($urandom_range(0, 6)) - 3);
        end
        send(it);
        sent++;
      end
      if ($urandom_range(0, 15) == 0) begin
        it = make_load(1'b1);
        it.action = tsdm_pkg::ACT_NOP;
        send(it);
        sent++;
      end
    end
    item_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: stall pattern with changing density, plus one long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int phase_cnt = 0;

  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1;
    if (phase_cnt % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_requests > hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    tsdm_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting");
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", result.status, want.status));
        if (result.distance !== want.distance)
          report_mismatch($sformatf("distance %0d, expected %0d",
                                    result.distance, want.distance));
        if (result.inside_res !== want.inside_res)
          report_mismatch($sformatf("inside %0b, expected %0b",
                                    result.inside_res, want.inside_res));
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
